>>> hw/rtl/rbm_pkg.sv
// Package for the RSA block modexp: widths, register indexes, a control struct.
// No dependencies.
package rbm_pkg;
	localparam int unsigned RegW = 31;
	localparam int unsigned BaseW = RegW + 1;
	localparam int unsigned IdxW = 2;
	localparam logic [IdxW-1:0] RegModulus = 2'd0;
	localparam logic [IdxW-1:0] RegPubExp  = 2'd1;
	localparam logic [IdxW-1:0] RegPrivExp = 2'd2;
	localparam logic [RegW-1:0] ModulusRst = 31'd256;
	localparam logic [RegW-1:0] PubExpRst  = 31'd3;
	localparam logic [RegW-1:0] PrivExpRst = 31'd1;
	localparam logic OpEnc = 1'b0;
	localparam logic OpDec = 1'b1;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} mm_ctl_t;
endpackage

>>> hw/rtl/rsa_block_modexp.sv
// Top level of the RSA block modexp: config registers, input masking, output beat.
// Depends on rbm_pkg, rbm_ctrl.
//   channel | dir | handshake          | payload
//   in      | in  | in_valid/in_ready  | op, block_in, last_in
//   out     | out | out_valid/out_ready| block_out, last_out
//   cfg     | in  | cfg_we             | cfg_idx, cfg_data
// One item at a time. Each modular multiply steps the bit-cell chain, the base
// reduction over the full base width; a nonzero exponent e costs the base
// reduction, one squaring per bit of e above the lowest and one multiply per
// set bit before out_valid; a zero exponent skips all multiplies. Reset sets
// the registers to their defaults. A result held on out waits for out_ready;
// the next beat is taken only after that.
module rsa_block_modexp import rbm_pkg::*; #(
	parameter int unsigned WORD_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [IdxW-1:0]       cfg_idx,
	input  logic [RegW-1:0]       cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  op,
	input  logic [WORD_WIDTH-1:0] block_in,
	input  logic                  last_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [RegW-1:0]       block_out,
	output logic                  last_out
);
	logic [RegW-1:0]  mod_q, pub_q, priv_q;
	logic             busy_q, op_q, last_q, ov_q;
	logic [BaseW-1:0] base, bmask;
	logic [RegW-1:0]  expo, res;
	logic [RegW-1:0]  bo_q;
	logic             fin, go;
	logic [5:0]       blen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q  <= ModulusRst;
			pub_q  <= PubExpRst;
			priv_q <= PrivExpRst;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				RegModulus: mod_q  <= cfg_data;
				RegPubExp:  pub_q  <= cfg_data;
				RegPrivExp: priv_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		blen = '0;
		for (int i = 0; i < RegW; i++) begin
			if (mod_q[i]) blen = 6'(i + 1);
		end
		bmask = '0;
		for (int i = 0; i < BaseW; i++) begin
			if (6'(i) < {blen[5:3] + (blen[2:0] != 3'd0 ? 3'd1 : 3'd0), 3'b000})
				bmask[i] = 1'b1;
		end
	end

	assign go       = in_valid && in_ready;
	assign in_ready = !busy_q && !ov_q;
	assign base = (op == OpDec) ? (BaseW'(block_in) & bmask)
		: {{(BaseW-8){1'b0}}, block_in[7:0]};
	assign expo = (op == OpDec) ? priv_q : pub_q;

	rbm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .go(go), .base(base), .expo(expo),
		.n(mod_q), .fin(fin), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
			op_q   <= 1'b0;
			last_q <= 1'b0;
			bo_q   <= '0;
		end else begin
			if (go) begin
				busy_q <= 1'b1;
				op_q   <= op;
				last_q <= last_in;
			end
			if (fin) begin
				busy_q <= 1'b0;
				ov_q   <= 1'b1;
				bo_q   <= (op_q == OpDec) ? {{(RegW-8){1'b0}}, res[7:0]} : res;
			end else if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign out_valid = ov_q;
	assign block_out = bo_q;
	assign last_out  = last_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !in_ready) else $error("accept while busy");
	a_fin_sets_out: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> out_valid) else $error("result lost");
	a_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && ov_q)) else $error("busy with pending beat");
endmodule

>>> hw/rtl/rbm_cell.sv
// One bit cell of the interleaved modular multiplier chain.
// Depends on rbm_pkg.
module rbm_cell import rbm_pkg::*; (
	input  logic clk,
	input  logic load,
	input  logic shift,
	input  logic d_in,
	input  logic d_init,
	output logic d_q
);
	always_ff @(posedge clk) begin
		if (load) begin
			d_q <= d_init;
		end else if (shift) begin
			d_q <= d_in;
		end
	end
endmodule

>>> hw/rtl/rbm_mulmod.sv
// Modular multiplier: multiplier bits stream MSB first through a chain of
// bit cells; one shift-add-reduce step per cycle. Depends on rbm_pkg, rbm_cell.
module rbm_mulmod import rbm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             wide,
	input  logic [RegW-1:0]  x,
	input  logic [BaseW-1:0] y,
	input  logic [RegW-1:0]  n,
	output logic [RegW-1:0]  p,
	output mm_ctl_t          ctl
);
	localparam int unsigned CntW = $clog2(BaseW + 1);
	logic [BaseW-1:0] chain;
	logic [BaseW-1:0] y_ld;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [RegW-1:0]  acc_q;
	logic [RegW+1:0]  dbl, add1, red1, red2;

	// narrow operands skip the always-zero top bit
	assign y_ld = wide ? y : {y[BaseW-2:0], 1'b0};

	for (genvar i = 0; i < BaseW; i++) begin : g_cell
		rbm_cell u_cell (
			.clk   (clk),
			.load  (start),
			.shift (busy_q),
			.d_in  ((i == 0) ? 1'b0 : chain[(i == 0) ? 0 : i-1]),
			.d_init(y_ld[i]),
			.d_q   (chain[i])
		);
	end

	always_comb begin
		dbl  = {1'b0, acc_q, 1'b0};
		red1 = (dbl >= {2'b0, n}) ? dbl - {2'b0, n} : dbl;
		add1 = red1 + (chain[BaseW-1] ? {2'b0, x} : '0);
		red2 = (add1 >= {2'b0, n}) ? add1 - {2'b0, n} : add1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CntW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= wide ? CntW'(BaseW) : CntW'(RegW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (n == '0) ? '0 : red2[RegW-1:0];
		end
	end

	assign p = acc_q;
	assign ctl = '{start: start, busy: busy_q, done: done_q};
endmodule

>>> hw/rtl/rbm_ctrl.sv
// Square-and-multiply sequencer over the exponent, LSB first.
// Base pre-reduction is done as 1*base mod n. Depends on rbm_pkg, rbm_mulmod.
module rbm_ctrl import rbm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [BaseW-1:0] base,
	input  logic [RegW-1:0]  expo,
	input  logic [RegW-1:0]  n,
	output logic             fin,
	output logic [RegW-1:0]  res
);
	typedef enum logic [2:0] {IDLE, RED, MUL, SQR, DONE} st_t;
	st_t              st_q;
	logic [RegW-1:0]  e_q, r_q;
	logic [BaseW-1:0] b_q;
	logic             mm_go;
	logic             wide;
	logic [RegW-1:0]  mx, mp;
	logic [BaseW-1:0] my;
	mm_ctl_t          mctl;
	logic             fin_q;

	rbm_mulmod u_mm (
		.clk(clk), .arst_n(arst_n), .start(mm_go), .wide(wide),
		.x(mx), .y(my), .n(n), .p(mp), .ctl(mctl)
	);

	always_comb begin
		mx   = b_q[RegW-1:0];
		wide = 1'b0;
		unique case (st_q)
			RED: begin
				mx   = RegW'(1);
				my   = b_q;
				wide = 1'b1;
			end
			SQR:     my = b_q;
			default: my = {1'b0, r_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= IDLE;
			mm_go <= 1'b0;
			fin_q <= 1'b0;
			e_q   <= '0;
			b_q   <= '0;
			r_q   <= '0;
		end else begin
			fin_q <= (st_q == DONE);
			mm_go <= ((st_q == IDLE) && go && (expo != '0)) ||
				((st_q == MUL) && mctl.done && (e_q[RegW-1:1] != '0)) ||
				(((st_q == RED) || (st_q == SQR)) && mctl.done);
			unique case (st_q)
				IDLE: if (go) begin
					e_q <= expo;
					b_q <= base;
					r_q <= RegW'(1);
					if (expo == '0) begin
						st_q <= DONE;
					end else begin
						st_q <= RED;
					end
				end
				RED: if (mctl.done) begin
					b_q <= {1'b0, mp};
					if (e_q[0]) begin
						st_q <= MUL;
					end else begin
						st_q <= SQR;
					end
				end
				MUL: if (mctl.done) begin
					r_q <= mp;
					if (e_q[RegW-1:1] == '0) begin
						st_q <= DONE;
					end else begin
						st_q <= SQR;
					end
				end
				SQR: if (mctl.done) begin
					b_q  <= {1'b0, mp};
					e_q  <= e_q >> 1;
					st_q <= e_q[1] ? MUL : SQR;
				end
				DONE: begin
					st_q <= IDLE;
				end
				default: st_q <= IDLE;
			endcase
		end
	end

	assign fin = fin_q;
	assign res = r_q;
endmodule
